[rtl/core/lop_pkg.sv]
// ----------------------------------------------------------------------------
// lop_pkg
// Shared types and constants of the LRU order list: list depth, field
// widths, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package lop_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int ADDR_W     = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int BLOCK_W    = 6;

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_PREPEND  = 3'd1,
    OP_RMFIRST  = 3'd2,
    OP_RMLAST   = 3'd3,
    OP_RMBLOCK  = 3'd4,
    OP_MVEND    = 3'd5,
    OP_MVBEGIN  = 3'd6,
    OP_CLEAR    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAIL_RD,
    S_TAIL_CHK,
    S_SCAN,
    S_DOWN,
    S_UP,
    S_DONE
  } state_e;

endpackage

[rtl/core/lop_ram.sv]
// ----------------------------------------------------------------------------
// lop_ram
// Generic RAM with one write port and one read port; read data is
// registered and shows the old contents on a same-address write.
// ----------------------------------------------------------------------------
module lop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/core/lru_order_list_top.sv]
// ----------------------------------------------------------------------------
// lru_order_list_top
// Ordered list of cache block numbers for replacement order, kept in an order
// memory with one read and one write port and worked on by a small sequencer.
// ----------------------------------------------------------------------------
// Append, clear, a move on a single entry, a move to the beginning of the head
// block and every request refused as empty or full need no memory read; remove
// last and a remove block or move to the end that hits the tail entry read the
// tail only. Remove first and prepend shift the whole list, any other remove
// block or move to the end searches from the head and then shifts, and a move
// to the beginning that must search also reinserts at the head. The order
// memory reads one entry per cycle for the search and for the shifts that
// close or open a gap. A new request is taken only while the block is idle,
// and a finished result may wait in the output register.
module lru_order_list_top
  import lop_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [BLOCK_W-1:0] block_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [BLOCK_W-1:0] removed_block_o,
  output logic [CNT_W-1:0]   entry_count_o,
  output logic [BLOCK_W-1:0] head_block_o
);

  state_e             state_q, state_d;
  op_e                op_q, op_d, op_in;
  logic [BLOCK_W-1:0] block_q, block_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [BLOCK_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ADDR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic               pend_q, pend_d;
  status_e            status_q, status_d;
  logic [BLOCK_W-1:0] removed_q, removed_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q;
  logic [BLOCK_W-1:0] out_removed_q;
  logic [CNT_W-1:0]   out_count_q;
  logic [BLOCK_W-1:0] out_head_q;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [BLOCK_W-1:0] ram_wdata, ram_rdata;

  logic               list_empty, list_full, list_single;
  logic               rd_match, rd_more, down_fin, up_fin, out_free, load_out;
  logic [CNT_W-1:0]   cnt_last;

  lop_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign op_in       = op_e'(op_i);
  assign in_stall_o  = (state_q != S_IDLE);
  assign list_empty  = (count_q == '0);
  assign list_full   = (count_q == CNT_W'(MAX_BLOCKS));
  assign list_single = (count_q == CNT_W'(1));
  assign cnt_last    = count_q - CNT_W'(1);
  assign rd_match    = (ram_rdata == block_q);
  assign rd_more     = (rd_ptr_q < count_q);
  assign down_fin    = !pend_q && !rd_more;
  assign up_fin      = !pend_q && (rd_ptr_q == '0);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign load_out    = (state_q == S_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_in)
            OP_APPEND, OP_CLEAR: state_d = S_DONE;
            OP_PREPEND:          state_d = list_full ? S_DONE : S_UP;
            OP_RMFIRST:          state_d = list_empty ? S_DONE : S_DOWN;
            OP_RMLAST,
            OP_RMBLOCK:          state_d = list_empty ? S_DONE : S_TAIL_RD;
            OP_MVEND: begin
              state_d = (list_empty || list_single) ? S_DONE : S_TAIL_RD;
            end
            OP_MVBEGIN: begin
              state_d = (list_empty || list_single || head_q == block_i) ?
                        S_DONE : S_TAIL_RD;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_TAIL_RD: state_d = S_TAIL_CHK;
      S_TAIL_CHK: begin
        if (op_q == OP_RMLAST) begin
          state_d = S_DONE;
        end else if (rd_match) begin
          state_d = (op_q == OP_MVBEGIN) ? S_DOWN : S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pend_q && rd_match) begin
          state_d = S_DOWN;
        end else if (rd_ptr_q == count_q) begin
          state_d = S_DONE;
        end
      end
      S_DOWN: begin
        if (down_fin) begin
          state_d = (op_q == OP_MVBEGIN) ? S_UP : S_DONE;
        end
      end
      S_UP: begin
        if (up_fin) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d      = op_q;
    block_d   = block_q;
    count_d   = count_q;
    head_d    = head_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    pend_d    = pend_q;
    status_d  = status_q;
    removed_d = removed_q;
    ram_we    = 1'b0;
    ram_waddr = wr_ptr_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = rd_ptr_q[ADDR_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_in;
          block_d   = block_i;
          status_d  = STAT_OK;
          removed_d = '0;
          pend_d    = 1'b0;
          unique case (op_in)
            OP_APPEND: begin
              if (list_full) begin
                status_d = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[ADDR_W-1:0];
                ram_wdata = block_i;
                count_d   = count_q + CNT_W'(1);
              end
            end
            OP_PREPEND: begin
              if (list_full) begin
                status_d = STAT_FULL;
              end else begin
                rd_ptr_d = count_q;
              end
            end
            OP_RMFIRST: begin
              if (list_empty) begin
                status_d = STAT_EMPTY;
              end else begin
                removed_d = head_q;
                wr_ptr_d  = '0;
                rd_ptr_d  = CNT_W'(1);
              end
            end
            OP_RMLAST, OP_RMBLOCK: begin
              if (list_empty) begin
                status_d = STAT_EMPTY;
              end
            end
            OP_MVEND, OP_MVBEGIN: begin
              if (list_empty) begin
                status_d = STAT_EMPTY;
              end else if (list_single && head_q != block_i) begin
                status_d = STAT_NOTFOUND;
              end
            end
            OP_CLEAR: count_d = '0;
            default: count_d = count_q;
          endcase
        end
      end
      S_TAIL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_last[ADDR_W-1:0];
      end
      S_TAIL_CHK: begin
        if (op_q == OP_RMLAST) begin
          removed_d = ram_rdata;
          count_d   = cnt_last;
        end else if (rd_match) begin
          if (op_q == OP_RMBLOCK) begin
            removed_d = block_q;
            count_d   = cnt_last;
          end else if (op_q == OP_MVBEGIN) begin
            wr_ptr_d = cnt_last[ADDR_W-1:0];
            rd_ptr_d = count_q;
          end
        end else begin
          rd_ptr_d = '0;
          pend_d   = 1'b0;
        end
      end
      S_SCAN: begin
        if (pend_q && rd_match) begin
          wr_ptr_d = ADDR_W'(rd_ptr_q - CNT_W'(1));
          pend_d   = 1'b0;
          if (op_q == OP_RMBLOCK) begin
            removed_d = block_q;
          end
        end else if (rd_ptr_q == count_q) begin
          status_d = STAT_NOTFOUND;
        end else begin
          ram_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + CNT_W'(1);
          pend_d   = 1'b1;
        end
      end
      S_DOWN: begin
        if (pend_q) begin
          ram_we   = 1'b1;
          wr_ptr_d = wr_ptr_q + ADDR_W'(1);
        end
        if (rd_more) begin
          ram_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + CNT_W'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (down_fin) begin
          if (op_q == OP_MVEND) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_last[ADDR_W-1:0];
            ram_wdata = block_q;
          end else begin
            count_d = cnt_last;
            if (op_q == OP_MVBEGIN) begin
              rd_ptr_d = cnt_last;
            end
          end
        end
      end
      S_UP: begin
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (rd_ptr_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(rd_ptr_q - CNT_W'(1));
          wr_ptr_d  = ADDR_W'(rd_ptr_q);
          rd_ptr_d  = rd_ptr_q - CNT_W'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (up_fin) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = block_q;
          count_d   = count_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        ram_we = 1'b0;
      end
      default: ram_we = 1'b0;
    endcase

    if (ram_we && ram_waddr == '0) begin
      head_d = ram_wdata;
    end
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    block_q   <= block_d;
    head_q    <= head_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    if (load_out) begin
      out_status_q  <= status_q;
      out_removed_q <= removed_q;
      out_count_q   <= count_q;
      out_head_q    <= list_empty ? '0 : head_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_block_o = out_removed_q;
  assign entry_count_o   = out_count_q;
  assign head_block_o    = out_head_q;

endmodule

[bench/tb_lru_order_list_top.sv]
// ----------------------------------------------------------------------------
// tb_lru_order_list_top
// Self-checking bench for the LRU order list. A scoreboard keeps its own copy
// of the ordered block list, predicts status, removed block, entry count and
// head block for every accepted request, and compares each result in order.
// Stimulus is a short directed sweep of the empty, single-entry, in-place and
// duplicate cases, then random batches that grow, drain and churn the list,
// with random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_lru_order_list_top
  import lop_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_REQS = 1700;

  typedef struct packed {
    status_e              status;
    logic [BLOCK_W-1:0]   removed;
    logic [CNT_W-1:0]     count;
    logic [BLOCK_W-1:0]   head;
  } list_result_t;

  class lru_list_scoreboard;
    logic [BLOCK_W-1:0] blocks[$];
    list_result_t       expected_q[$];
    int                 errors;
    int                 checked;
    int                 peak_depth;
    int                 status_count[4];

    // Index that remove-block would take: the tail if it matches, else the
    // first match from the head, or -1 when the block is absent.
    function int victim_index(logic [BLOCK_W-1:0] blk);
      if (blocks.size() == 0) return -1;
      if (blocks[blocks.size() - 1] == blk) return blocks.size() - 1;
      foreach (blocks[i]) if (blocks[i] == blk) return i;
      return -1;
    endfunction

    function void note_request(op_e op, logic [BLOCK_W-1:0] blk);
      list_result_t r;
      int           pos;
      r.status  = STAT_OK;
      r.removed = '0;
      case (op)
        OP_APPEND, OP_PREPEND: begin
          if (blocks.size() >= MAX_BLOCKS) r.status = STAT_FULL;
          else if (op == OP_APPEND) blocks.push_back(blk);
          else blocks.push_front(blk);
        end
        OP_RMFIRST, OP_RMLAST: begin
          if (blocks.size() == 0) r.status = STAT_EMPTY;
          else if (op == OP_RMFIRST) r.removed = blocks.pop_front();
          else r.removed = blocks.pop_back();
        end
        OP_RMBLOCK: begin
          pos = victim_index(blk);
          if (blocks.size() == 0) r.status = STAT_EMPTY;
          else if (pos < 0) r.status = STAT_NOTFOUND;
          else begin
            r.removed = blocks[pos];
            blocks.delete(pos);
          end
        end
        OP_MVEND, OP_MVBEGIN: begin
          pos = victim_index(blk);
          if (blocks.size() == 0) r.status = STAT_EMPTY;
          else if (blocks.size() == 1) begin
            r.status = (blocks[0] == blk) ? STAT_OK : STAT_NOTFOUND;
          end else if (op == OP_MVEND && blocks[blocks.size() - 1] == blk) begin
            r.status = STAT_OK;
          end else if (op == OP_MVBEGIN && blocks[0] == blk) begin
            r.status = STAT_OK;
          end else if (pos < 0) begin
            r.status = STAT_NOTFOUND;
          end else begin
            blocks.delete(pos);
            if (op == OP_MVEND) blocks.push_back(blk);
            else blocks.push_front(blk);
          end
        end
        default: blocks.delete();
      endcase
      r.count = CNT_W'(blocks.size());
      r.head  = (blocks.size() > 0) ? blocks[0] : '0;
      if (blocks.size() > peak_depth) peak_depth = blocks.size();
      status_count[r.status]++;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [BLOCK_W-1:0] removed,
                               logic [CNT_W-1:0] count, logic [BLOCK_W-1:0] head);
      list_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: status %0d count %0d", status, count);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (removed !== e.removed) begin
        $error("removed_block: expected %0d, actual %0d", e.removed, removed);
        errors++;
      end
      if (count !== e.count) begin
        $error("entry_count: expected %0d, actual %0d", e.count, count);
        errors++;
      end
      if (head !== e.head) begin
        $error("head_block: expected %0d, actual %0d", e.head, head);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         op_i = OP_APPEND;
  logic [BLOCK_W-1:0] block_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [BLOCK_W-1:0] removed_block_o;
  logic [CNT_W-1:0]   entry_count_o;
  logic [BLOCK_W-1:0] head_block_o;

  lru_list_scoreboard sb = new();
  int unsigned        cycles = 0;

  lru_order_list_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .block_i         (block_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .removed_block_o (removed_block_o),
    .entry_count_o   (entry_count_o),
    .head_block_o    (head_block_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_req(op_e op, logic [BLOCK_W-1:0] blk, bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    block_i    <= blk;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, blk);
  endtask

  initial begin : result_sink
    int hold;
    bit calm;
    hold = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(status_o, removed_block_o, entry_count_o, head_block_o);
        if ($urandom_range(0, 29) == 0) calm = !calm;
        hold = calm ? 0 : $urandom_range(0, 3);
        if (sb.checked == 400) hold = 300;
        out_stall_i <= (hold > 0);
      end else if (out_stall_i) begin
        hold--;
        if (hold == 0) out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : request_source
    int                 sent;
    int                 batch;
    int                 mode;
    int                 roll;
    bit                 calm;
    op_e                op;
    logic [BLOCK_W-1:0] blk;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(OP_RMFIRST, 6'd0, 1'b0);
    send_req(OP_RMLAST, 6'd63, 1'b0);
    send_req(OP_RMBLOCK, 6'd63, 1'b0);
    send_req(OP_MVEND, 6'd0, 1'b0);
    send_req(OP_MVBEGIN, 6'd63, 1'b0);
    send_req(OP_CLEAR, 6'd0, 1'b0);
    send_req(OP_APPEND, 6'd63, 1'b0);
    send_req(OP_MVEND, 6'd63, 1'b0);
    send_req(OP_MVBEGIN, 6'd5, 1'b0);
    send_req(OP_RMBLOCK, 6'd0, 1'b0);
    send_req(OP_PREPEND, 6'd0, 1'b0);
    send_req(OP_APPEND, 6'd42, 1'b0);
    send_req(OP_APPEND, 6'd0, 1'b0);
    send_req(OP_MVBEGIN, 6'd0, 1'b0);
    send_req(OP_MVEND, 6'd0, 1'b0);
    send_req(OP_MVBEGIN, 6'd42, 1'b0);
    send_req(OP_MVEND, 6'd63, 1'b0);
    send_req(OP_RMBLOCK, 6'd0, 1'b0);
    send_req(OP_RMBLOCK, 6'd9, 1'b0);
    send_req(OP_MVEND, 6'd21, 1'b0);
    send_req(OP_RMFIRST, 6'd63, 1'b0);
    send_req(OP_RMLAST, 6'd0, 1'b0);
    send_req(OP_CLEAR, 6'd63, 1'b0);

    // Each batch picks at random between growing the list toward full, draining
    // it and mixed churn.
    sent = 0;
    while (sent < RANDOM_REQS) begin
      batch = $urandom_range(40, 160);
      if (batch > RANDOM_REQS - sent) batch = RANDOM_REQS - sent;
      mode  = $urandom_range(0, 3);
      calm  = ($urandom_range(0, 3) == 0);
      repeat (batch) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0: op = (roll < 45) ? OP_APPEND :
                  (roll < 85) ? OP_PREPEND :
                  op_e'($urandom_range(int'(OP_RMBLOCK), int'(OP_MVBEGIN)));
          1: op = (roll < 25) ? OP_RMFIRST :
                  (roll < 50) ? OP_RMLAST :
                  (roll < 80) ? OP_RMBLOCK :
                  (roll < 95) ? op_e'($urandom_range(int'(OP_MVEND), int'(OP_MVBEGIN))) :
                  OP_APPEND;
          default: op = (roll < 2) ? OP_CLEAR :
                        op_e'($urandom_range(int'(OP_APPEND), int'(OP_MVBEGIN)));
        endcase
        if (op inside {OP_RMBLOCK, OP_MVEND, OP_MVBEGIN} && sb.blocks.size() > 0 &&
            $urandom_range(0, 3) != 0) begin
          blk = sb.blocks[$urandom_range(0, sb.blocks.size() - 1)];
        end else if ($urandom_range(0, 1) == 0) begin
          blk = BLOCK_W'($urandom_range(0, 7));
        end else begin
          blk = BLOCK_W'($urandom_range(0, 63));
        end
        send_req(op, blk, calm);
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d requests over all eight list operations, list depth up to %0d.",
             sb.checked, sb.peak_depth);
    $display("Results: %0d done, %0d empty, %0d not found, %0d refused as full.",
             sb.status_count[STAT_OK], sb.status_count[STAT_EMPTY],
             sb.status_count[STAT_NOTFOUND], sb.status_count[STAT_FULL]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
